[design/tcw_pkg.sv]
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned CodeW  = 8;
  localparam int unsigned RowIdxW = 5;
  localparam int unsigned CellIdxW = 11;
  localparam int unsigned OffsW  = 11;

  localparam logic [CodeW-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CodeW-1:0] BLANK_CODE   = 8'd32;
  localparam logic [CodeW-1:0] RESET_ATTR   = 8'd15;

  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_CLR_SCREEN = 2'd1,
    CMD_CLR_ROW   = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                command;
    logic [CodeW-1:0]    char_code;
    logic [CodeW-1:0]    char_attr;
    logic [RowIdxW-1:0]  row_index;
    logic [CellIdxW-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [OffsW-1:0] cursor_offset;
    logic [CodeW-1:0] read_char;
    logic [CodeW-1:0] read_attr;
    logic             scrolled;
    logic             request_error;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_IDLE     = 3'd1,
    ST_DECODE   = 3'd2,
    ST_COPY     = 3'd3,
    ST_COPY_END = 3'd4,
    ST_BLANK    = 3'd5,
    ST_READ     = 3'd6,
    ST_RESP     = 3'd7
  } state_e;

  // Sweep pointer loads: start and end of the address range to walk.
  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_ALL  = 3'd1,
    PTR_ROW  = 3'd2,
    PTR_COPY = 3'd3,
    PTR_LAST = 3'd4
  } ptr_ld_e;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_INIT  = 2'd1,
    WR_BLANK = 2'd2,
    WR_PUT   = 2'd3
  } wr_sel_e;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_COPY = 2'd1,
    RD_CELL = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    CUR_HOLD = 3'd0,
    CUR_ZERO = 3'd1,
    CUR_ROW  = 3'd2,
    CUR_PUT  = 3'd3,
    CUR_LAST = 3'd4
  } cur_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    ptr_ld_e ptr_ld;
    logic    ptr_inc;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    cur_op_e cur_op;
    logic    set_scrolled;
    logic    rd_capture;
    logic    out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic wraps;
    logic last_row;
    logic req_ok;
    logic ptr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/tcw_dpath.sv]
// Datapath of the text console writer: cell store, cursor, sweep pointer and result register.
`default_nettype none

module tcw_dpath #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire tcw_pkg::in_item_t in_item_i,
  input  wire tcw_pkg::ctl_t     ctl_i,
  output tcw_pkg::sts_t          sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tcw_pkg::out_item_t     out_item_o
);
  import tcw_pkg::*;

  localparam int Cells = ROWS * COLS;
  localparam int AW    = $clog2(Cells);
  localparam int RowW  = $clog2(ROWS);
  localparam int ColW  = $clog2(COLS);

  logic [CodeW-1:0] attr_q;
  in_item_t         req_q;
  logic [AW-1:0]    ptr_q, end_q;
  logic [RowW-1:0]  cur_row_q;
  logic [ColW-1:0]  cur_col_q;
  logic             cp_vld_q;
  logic [AW-1:0]    cp_addr_q;
  logic             scrolled_q;
  logic [CodeW-1:0] rd_char_q, rd_attr_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [RowW-1:0]  req_row;
  logic [AW-1:0]    row_base, cur_lin;
  logic             row_ok, cell_ok, is_nl, wraps, last_row, req_err;
  logic [CodeW-1:0] put_attr;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata, mem_rdata;

  // Decode of the held request and the cursor position.
  assign req_row  = RowW'(req_q.row_index);
  assign row_base = AW'(req_row) * AW'(COLS);
  assign cur_lin  = AW'(cur_row_q) * AW'(COLS) + AW'(cur_col_q);
  assign row_ok   = 32'(req_q.row_index) < ROWS;
  assign cell_ok  = 32'(req_q.cell_index) < Cells;
  assign is_nl    = req_q.char_code == NEWLINE_CODE;
  assign wraps    = is_nl || (cur_col_q == ColW'(COLS - 1));
  assign last_row = cur_row_q == RowW'(ROWS - 1);
  assign put_attr = (req_q.char_attr == '0) ? attr_q : req_q.char_attr;
  assign req_err  = ((req_q.command == CMD_CLR_ROW) && !row_ok) ||
                    ((req_q.command == CMD_READ) && !cell_ok);

  always_comb begin
    sts_o.cmd      = req_q.command;
    sts_o.wraps    = wraps;
    sts_o.last_row = last_row;
    sts_o.req_ok   = (req_q.command == CMD_CLR_ROW) ? row_ok : cell_ok;
    sts_o.ptr_last = ptr_q == end_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Write port: the pending scroll copy takes precedence over everything else.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = {attr_q, BLANK_CODE};
    if (cp_vld_q) begin
      mem_we    = 1'b1;
      mem_waddr = cp_addr_q;
      mem_wdata = mem_rdata;
    end else begin
      unique case (ctl_i.wr_sel)
        WR_INIT: begin
          mem_we    = 1'b1;
          mem_wdata = {RESET_ATTR, BLANK_CODE};
        end
        WR_BLANK: begin
          mem_we = 1'b1;
        end
        WR_PUT: begin
          mem_we    = !is_nl;
          mem_waddr = cur_lin;
          mem_wdata = {put_attr, req_q.char_code};
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  assign mem_raddr = (ctl_i.rd_sel == RD_CELL) ? AW'(req_q.cell_index) : ptr_q;

  tcw_ram #(
    .Width(16),
    .Depth(Cells)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Default attribute register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // Request holding register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      req_q <= in_item_i;
    end
  end

  // Sweep pointer and its end mark; reset leaves them set for the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      end_q <= AW'(Cells - 1);
    end else begin
      unique case (ctl_i.ptr_ld)
        PTR_ALL: begin
          ptr_q <= '0;
          end_q <= AW'(Cells - 1);
        end
        PTR_ROW: begin
          ptr_q <= row_base;
          end_q <= row_base + AW'(COLS - 1);
        end
        PTR_COPY: begin
          ptr_q <= AW'(COLS);
          end_q <= AW'(Cells - 1);
        end
        PTR_LAST: begin
          ptr_q <= AW'((ROWS - 1) * COLS);
          end_q <= AW'(Cells - 1);
        end
        default: begin
          if (ctl_i.ptr_inc) begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
      endcase
    end
  end

  // Scroll copy pipeline: the cell read this cycle is written one row up next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_vld_q <= 1'b0;
    end else begin
      cp_vld_q <= ctl_i.rd_sel == RD_COPY;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= ptr_q - AW'(COLS);
  end

  // Cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      cur_col_q <= '0;
    end else begin
      unique case (ctl_i.cur_op)
        CUR_ZERO: begin
          cur_row_q <= '0;
          cur_col_q <= '0;
        end
        CUR_ROW: begin
          cur_row_q <= req_row;
          cur_col_q <= '0;
        end
        CUR_PUT: begin
          if (!wraps) begin
            cur_col_q <= cur_col_q + 1'b1;
          end else if (!last_row) begin
            cur_row_q <= cur_row_q + 1'b1;
            cur_col_q <= '0;
          end
        end
        CUR_LAST: begin
          cur_row_q <= RowW'(ROWS - 1);
          cur_col_q <= '0;
        end
        default: begin
          cur_row_q <= cur_row_q;
        end
      endcase
    end
  end

  // Per-item result flags and read data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      scrolled_q <= 1'b0;
      rd_char_q  <= '0;
      rd_attr_q  <= '0;
    end else begin
      if (ctl_i.set_scrolled) begin
        scrolled_q <= 1'b1;
      end
      if (ctl_i.rd_capture) begin
        rd_char_q <= mem_rdata[7:0];
        rd_attr_q <= mem_rdata[15:8];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_q.cursor_offset <= OffsW'(cur_lin);
      out_q.read_char     <= rd_char_q;
      out_q.read_attr     <= rd_attr_q;
      out_q.scrolled      <= scrolled_q;
      out_q.request_error <= req_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A scroll copy write must never collide with another store write.
  a_copy_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_vld_q |-> (ctl_i.wr_sel == WR_NONE))
    else $error("scroll copy write collides with another store write");

endmodule

`default_nettype wire

[design/tcw_ctrl.sv]
// Controller state machine of the text console writer.
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tcw_pkg::sts_t sts_i,
  output tcw_pkg::ctl_t      ctl_o
);
  import tcw_pkg::*;

  state_e state_q, state_d;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d            = state_q;
    in_ready_o         = 1'b0;
    ctl_o.capture      = 1'b0;
    ctl_o.ptr_ld       = PTR_HOLD;
    ctl_o.ptr_inc      = 1'b0;
    ctl_o.wr_sel       = WR_NONE;
    ctl_o.rd_sel       = RD_NONE;
    ctl_o.cur_op       = CUR_HOLD;
    ctl_o.set_scrolled = 1'b0;
    ctl_o.rd_capture   = 1'b0;
    ctl_o.out_load     = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        ctl_o.wr_sel  = WR_INIT;
        ctl_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.cmd)
          CMD_PUT: begin
            ctl_o.wr_sel = WR_PUT;
            ctl_o.cur_op = CUR_PUT;
            if (sts_i.wraps && sts_i.last_row) begin
              ctl_o.set_scrolled = 1'b1;
              ctl_o.ptr_ld       = PTR_COPY;
              state_d            = ST_COPY;
            end else begin
              state_d = ST_RESP;
            end
          end
          CMD_CLR_SCREEN: begin
            ctl_o.ptr_ld = PTR_ALL;
            ctl_o.cur_op = CUR_ZERO;
            state_d      = ST_BLANK;
          end
          CMD_CLR_ROW: begin
            if (sts_i.req_ok) begin
              ctl_o.ptr_ld = PTR_ROW;
              ctl_o.cur_op = CUR_ROW;
              state_d      = ST_BLANK;
            end else begin
              state_d = ST_RESP;
            end
          end
          CMD_READ: begin
            if (sts_i.req_ok) begin
              ctl_o.rd_sel = RD_CELL;
              state_d      = ST_READ;
            end else begin
              state_d = ST_RESP;
            end
          end
          default: begin
            state_d = ST_RESP;
          end
        endcase
      end
      ST_COPY: begin
        // Stream one cell per cycle from the row below.
        ctl_o.rd_sel  = RD_COPY;
        ctl_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_COPY_END;
        end
      end
      ST_COPY_END: begin
        // The last copy write drains here; then the bottom row is blanked.
        ctl_o.ptr_ld = PTR_LAST;
        ctl_o.cur_op = CUR_LAST;
        state_d      = ST_BLANK;
      end
      ST_BLANK: begin
        ctl_o.wr_sel  = WR_BLANK;
        ctl_o.ptr_inc = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_RESP;
        end
      end
      ST_READ: begin
        ctl_o.rd_capture = 1'b1;
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The copy sweep always hands over to the drain state once it reaches its end.
  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && sts_i.ptr_last) |=> (state_q == ST_COPY_END))
    else $error("copy sweep did not finish at its end mark");

  // A result is only loaded when the output register can take it.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an untaken result");

  // Read data is captured only in the cycle after the read was issued.
  a_read_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ($past(state_q) == ST_DECODE))
    else $error("read capture without a preceding read");

endmodule

`default_nettype wire

[design/text_console_writer.sv]
// Text console writer: character/attribute cell store with cursor, scroll and clear.
// An accepted item goes through decode to the result state; a read passes a read state,
// and clear row, clear screen and a scrolling put first sweep the affected cells, one
// cell per cycle over the store port.
// One item is in work at a time; the next is taken in the cycle after a result is loaded,
// even while that result waits to be taken.
`default_nettype none

module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tcw_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcw_pkg::out_item_t      out_item_o
);
  import tcw_pkg::*;

  // After reset the store is swept cell by cell to blank cells, with no item taken.
  ctl_t ctl;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  tcw_dpath #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_item_i  (in_item_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the text console writer: directed and random command items.
`default_nettype none

module testbench;
  import tcw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int CELLS = ROWS * COLS;
  localparam int RandomItems = 100;
  localparam int CycleLimit = 5_000_000;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  text_console_writer #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Free-running clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted console state: cell store, cursor and default attribute.
  logic [15:0] cells [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  dflt_attr;

  out_item_t expected_results[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;

  // Random gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Fill a span of cells with blanks in the current default attribute.
  function automatic void blank_cells(int first, int count);
    for (int i = first; i < first + count; i++) cells[i] = {dflt_attr, BLANK_CODE};
  endfunction

  // Apply one command item to the predicted console and return its result item.
  function automatic out_item_t console_step(in_item_t it);
    out_item_t  res;
    logic [7:0] attr;
    res = '0;
    case (it.command)
      CMD_PUT: begin
        attr = (it.char_attr == 8'd0) ? dflt_attr : it.char_attr;
        if (it.char_code != NEWLINE_CODE) begin
          cells[cur_row * COLS + cur_col] = {attr, it.char_code};
          cur_col++;
        end
        if (it.char_code == NEWLINE_CODE || cur_col >= COLS) begin
          if (cur_row + 1 < ROWS) begin
            cur_row++;
            cur_col = 0;
          end else begin
            // Scroll up one line and start again on a blank bottom row.
            for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
            blank_cells(CELLS - COLS, COLS);
            cur_row = ROWS - 1;
            cur_col = 0;
            res.scrolled = 1'b1;
          end
        end
      end
      CMD_CLR_SCREEN: begin
        blank_cells(0, CELLS);
        cur_row = 0;
        cur_col = 0;
      end
      CMD_CLR_ROW: begin
        if (int'(it.row_index) < ROWS) begin
          blank_cells(int'(it.row_index) * COLS, COLS);
          cur_row = int'(it.row_index);
          cur_col = 0;
        end else begin
          res.request_error = 1'b1;
        end
      end
      CMD_READ: begin
        if (int'(it.cell_index) < CELLS) begin
          res.read_char = cells[it.cell_index][7:0];
          res.read_attr = cells[it.cell_index][15:8];
        end else begin
          res.request_error = 1'b1;
        end
      end
    endcase
    res.cursor_offset = OffsW'(cur_row * COLS + cur_col);
    return res;
  endfunction

  // Present one item, wait for it to be taken and record its expected result.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(console_step(it));
  endtask

  // Item with every field random, so unused fields carry noise.
  function automatic in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic put_char(input logic [7:0] code, input logic [7:0] attr);
    in_item_t it;
    it = noise_item();
    it.command   = CMD_PUT;
    it.char_code = code;
    it.char_attr = attr;
    send_item(it);
  endtask

  task automatic send_clr_screen();
    in_item_t it;
    it = noise_item();
    it.command = CMD_CLR_SCREEN;
    send_item(it);
  endtask

  task automatic send_clr_row(input int row);
    in_item_t it;
    it = noise_item();
    it.command   = CMD_CLR_ROW;
    it.row_index = RowIdxW'(row);
    send_item(it);
  endtask

  task automatic read_cell(input int idx);
    in_item_t it;
    it = noise_item();
    it.command    = CMD_READ;
    it.cell_index = CellIdxW'(idx);
    send_item(it);
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic wait_results();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Change the default attribute while the block is idle.
  task automatic write_attr(input logic [7:0] value);
    wait_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dflt_attr = value;
  endtask

  // Result receiver: ready with random stalls.
  initial begin : ready_driver
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = calm ? 0 : pick_gap();
      if (stall == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting: %h", out_item_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.cursor_offset !== want.cursor_offset) begin
          $error("cursor_offset: expected %0d, got %0d",
                 want.cursor_offset, out_item_o.cursor_offset);
          fail_count++;
        end
        if (out_item_o.read_char !== want.read_char) begin
          $error("read_char: expected %0d, got %0d", want.read_char, out_item_o.read_char);
          fail_count++;
        end
        if (out_item_o.read_attr !== want.read_attr) begin
          $error("read_attr: expected %0d, got %0d", want.read_attr, out_item_o.read_attr);
          fail_count++;
        end
        if (out_item_o.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want.scrolled, out_item_o.scrolled);
          fail_count++;
        end
        if (out_item_o.request_error !== want.request_error) begin
          $error("request_error: expected %0b, got %0b",
                 want.request_error, out_item_o.request_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The store must come out of reset blank with the reset attribute; reads past its end are rejected.
  task automatic test_reset_state();
    read_cell(0);
    read_cell(CELLS / 2);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2047);
  endtask

  // Puts with extreme codes and attributes, including the default attribute.
  task automatic test_put_extremes();
    put_char(8'h41, 8'h00);
    put_char(8'h00, 8'hFF);
    put_char(8'hFF, 8'h01);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    put_char(NEWLINE_CODE, 8'h5A);
    read_cell(COLS);
  endtask

  // Clear commands, in range and out of range.
  task automatic test_clear_and_errors();
    send_clr_row(31);
    send_clr_row(ROWS);
    send_clr_row(0);
    read_cell(0);
    send_clr_screen();
    read_cell(1);
  endtask

  // A newline on the last row scrolls the screen up one line.
  task automatic test_scroll_newline();
    send_clr_row(ROWS - 1);
    put_char(8'h5A, 8'h00);
    put_char(NEWLINE_CODE, 8'h00);
    read_cell(CELLS - 2 * COLS);
    read_cell(CELLS - COLS);
  endtask

  // Blank cells and zero-attribute puts follow the default attribute.
  task automatic test_default_attr();
    write_attr(8'h00);
    send_clr_row(3);
    put_char(8'h61, 8'h00);
    read_cell(3 * COLS);
    write_attr(8'hFF);
    send_clr_screen();
    put_char(8'h62, 8'h00);
    read_cell(0);
    read_cell(CELLS - 1);
  endtask

  // Full rows of characters: a wrap to the next row, then a wrap that scrolls.
  task automatic test_row_wrap();
    write_attr(8'($urandom_range(1, 254)));
    send_clr_row(ROWS - 2);
    calm = 1'b1;
    for (int i = 0; i < COLS; i++) put_char(8'($urandom_range(11, 255)), 8'($urandom));
    calm = 1'b0;
    for (int i = 0; i < COLS; i++) put_char(8'($urandom_range(11, 255)), 8'($urandom));
    for (int i = 0; i < 6; i++) read_cell($urandom_range(CELLS - 2 * COLS, CELLS - 1));
  endtask

  // Random mix of commands, with default attribute changes between phases.
  task automatic test_random_mix();
    int roll;
    int offs;
    int back;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 60 == 0) begin
        roll = $urandom_range(0, 3);
        write_attr(roll == 0 ? 8'h00 : roll == 1 ? 8'hFF : 8'($urandom));
      end
      calm = (n >= 40 && n < 60);
      // Now and then hold off until the block has answered everything.
      if ($urandom_range(0, 99) < 3) wait_results();
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        put_char(8'($urandom), $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
      end else if (roll < 63) begin
        put_char(NEWLINE_CODE, 8'($urandom));
      end else if (roll < 73) begin
        roll = $urandom_range(0, 9);
        if (roll < 3) send_clr_row($urandom_range(ROWS - 3, ROWS - 1));
        else if (roll < 7) send_clr_row($urandom_range(0, ROWS - 1));
        else send_clr_row($urandom_range(ROWS, 31));
      end else if (roll < 75) begin
        send_clr_screen();
      end else begin
        roll = $urandom_range(0, 99);
        offs = cur_row * COLS + cur_col;
        back = $urandom_range(1, 100);
        if (roll < 50 && offs >= back) read_cell(offs - back);
        else if (roll < 85) read_cell($urandom_range(0, CELLS - 1));
        else read_cell($urandom_range(CELLS, 2047));
      end
    end
  endtask

  // Reset, run every test in turn, then report.
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'h00;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    dflt_attr   = RESET_ATTR;
    cur_row     = 0;
    cur_col     = 0;
    blank_cells(0, CELLS);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_put_extremes();
    test_clear_and_errors();
    test_scroll_newline();
    test_default_attr();
    test_row_wrap();
    test_random_mix();
    wait_results();
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
